// ===== rtl/core/pfa_pkg.sv =====
// Shared constants and operation codes for the prime field arithmetic unit.
package pfa_pkg;
   localparam int MOD_WIDTH = 15;
   localparam logic [MOD_WIDTH-1:0] MOD_RESET = 15'd32749;
   localparam int MM_CNT_WIDTH = $clog2(MOD_WIDTH + 1);

   typedef logic [MOD_WIDTH-1:0] residue_type;
   typedef logic [1:0] op_type;

   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_MUL = 2'd1;
   localparam op_type OP_RED = 2'd2;
   localparam op_type OP_INV = 2'd3;
endpackage

// ===== rtl/core/pfa_modmul.sv =====
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module pfa_modmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pfa_pkg::residue_type x,
   input  pfa_pkg::residue_type y,
   input  pfa_pkg::residue_type m,
   output logic               done,
   output pfa_pkg::residue_type p
);
   import pfa_pkg::*;

   residue_type acc_ff, acc_in;
   residue_type x_ff, x_in;
   residue_type y_ff, y_in;
   logic [MM_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [MOD_WIDTH:0] dbl, dbl_red, sum, sum_red;

   // one step: acc = 2*acc + bit*x, kept below m
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum     = dbl_red + (y_ff[MOD_WIDTH-1] ? {1'b0, x_ff} : '0);
      sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
   end

   // sequence the steps
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum_red[MOD_WIDTH-1:0];
         y_in   = {y_ff[MOD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MM_CNT_WIDTH'(MOD_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule

// ===== rtl/core/prime_field_alu.sv =====
// Top level of the prime field arithmetic unit: add, multiply, reduce, inverse.
// The operands in use are first reduced bit-serially; multiply then makes one pass of the bit-serial
// multiplier, and inverse runs squarings and multiplies on it followed by a check multiply.
// One item at a time; the next item can be taken in the cycle after the result beat is loaded.
// Synchronous active-high reset; modulus resets to 32749, no clearing pass.
module prime_field_alu #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pfa_pkg::op_type          req_type,
   input  logic signed [OPERAND_WIDTH-1:0] req_operand_a,
   input  logic signed [OPERAND_WIDTH-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pfa_pkg::residue_type     rsp_result,
   output logic                     rsp_no_inverse,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  pfa_pkg::residue_type     csr_modulus
);
   import pfa_pkg::*;

   localparam int CNT_WIDTH = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED   = 4'd1;
   localparam logic [3:0] S_FIX   = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_MWAIT = 4'd4;
   localparam logic [3:0] S_ILOOP = 4'd5;
   localparam logic [3:0] S_ISQ   = 4'd6;
   localparam logic [3:0] S_IMUL  = 4'd7;
   localparam logic [3:0] S_CHK   = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   residue_type mod_ff;
   op_type op_ff, op_in;
   logic [OPERAND_WIDTH-1:0] opb_ff, opb_in;
   logic [OPERAND_WIDTH-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic sel_b_ff, sel_b_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   residue_type r_ff, r_in;
   residue_type ra_ff, ra_in;
   residue_type rb_ff, rb_in;
   residue_type sq_ff, sq_in;
   residue_type pw_ff, pw_in;
   residue_type e_ff, e_in;
   residue_type res_ff, res_in;
   logic flag_ff, flag_in;
   logic rsp_valid_ff, rsp_valid_in;
   residue_type rsp_result_ff, rsp_result_in;
   logic rsp_flag_ff, rsp_flag_in;

   logic mm_start, mm_done;
   residue_type mm_x, mm_y, mm_p;
   logic [MOD_WIDTH:0] red_sh, red_next, add_sum;
   residue_type fixed;
   logic req_fire;

   pfa_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .start (mm_start),
      .x     (mm_x),
      .y     (mm_y),
      .m     (mod_ff),
      .done  (mm_done),
      .p     (mm_p)
   );

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // reduction step, sign fix-up and modular add
   always_comb begin
      red_sh   = {r_ff, mag_ff[OPERAND_WIDTH-1]};
      red_next = (red_sh >= {1'b0, mod_ff}) ? red_sh - {1'b0, mod_ff} : red_sh;
      fixed    = (neg_ff && r_ff != '0) ? mod_ff - r_ff : r_ff;
      add_sum  = {1'b0, ra_ff} + {1'b0, rb_ff};
      add_sum  = (add_sum >= {1'b0, mod_ff}) ? add_sum - {1'b0, mod_ff} : add_sum;
   end

   // sequence one item
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      opb_in   = opb_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sel_b_in = sel_b_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      sq_in    = sq_ff;
      pw_in    = pw_ff;
      e_in     = e_ff;
      res_in   = res_ff;
      flag_in  = flag_ff;
      mm_start = 1'b0;
      mm_x     = sq_ff;
      mm_y     = sq_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_flag_in   = rsp_flag_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_type;
               opb_in   = req_operand_b;
               neg_in   = req_operand_a[OPERAND_WIDTH-1];
               mag_in   = neg_in ? (~req_operand_a + 1'b1) : req_operand_a;
               sel_b_in = 1'b0;
               cnt_in   = '0;
               r_in     = '0;
               if (mod_ff < MOD_WIDTH'(2)) begin
                  res_in   = '0;
                  flag_in  = (req_type == OP_INV);
                  state_in = S_DONE;
               end else begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            r_in   = red_next[MOD_WIDTH-1:0];
            mag_in = {mag_ff[OPERAND_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (sel_b_ff) begin
               rb_in    = fixed;
               state_in = S_EXEC;
            end else begin
               ra_in = fixed;
               if (op_ff == OP_ADD || op_ff == OP_MUL) begin
                  sel_b_in = 1'b1;
                  neg_in   = opb_ff[OPERAND_WIDTH-1];
                  mag_in   = neg_in ? (~opb_ff + 1'b1) : opb_ff;
                  cnt_in   = '0;
                  r_in     = '0;
                  state_in = S_RED;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            flag_in = 1'b0;
            case (op_ff)
               OP_ADD: begin
                  res_in   = add_sum[MOD_WIDTH-1:0];
                  state_in = S_DONE;
               end
               OP_MUL: begin
                  mm_start = 1'b1;
                  mm_x     = ra_ff;
                  mm_y     = rb_ff;
                  state_in = S_MWAIT;
               end
               OP_RED: begin
                  res_in   = ra_ff;
                  state_in = S_DONE;
               end
               default: begin
                  if (ra_ff == MOD_WIDTH'(1) || ra_ff == mod_ff - 1'b1) begin
                     res_in   = ra_ff;
                     state_in = S_DONE;
                  end else begin
                     e_in     = (mod_ff - MOD_WIDTH'(2)) >> 1;
                     sq_in    = ra_ff;
                     pw_in    = mod_ff[0] ? ra_ff : MOD_WIDTH'(1);
                     state_in = S_ILOOP;
                  end
               end
            endcase
         end
         S_MWAIT: begin
            if (mm_done) begin
               res_in   = mm_p;
               state_in = S_DONE;
            end
         end
         S_ILOOP: begin
            mm_start = 1'b1;
            if (e_ff == '0) begin
               mm_x     = pw_ff;
               mm_y     = ra_ff;
               state_in = S_CHK;
            end else begin
               mm_x     = sq_ff;
               mm_y     = sq_ff;
               state_in = S_ISQ;
            end
         end
         S_ISQ: begin
            if (mm_done) begin
               sq_in = mm_p;
               if (e_ff[0]) begin
                  mm_start = 1'b1;
                  mm_x     = pw_ff;
                  mm_y     = mm_p;
                  state_in = S_IMUL;
               end else begin
                  e_in     = e_ff >> 1;
                  state_in = S_ILOOP;
               end
            end
         end
         S_IMUL: begin
            if (mm_done) begin
               pw_in    = mm_p;
               e_in     = e_ff >> 1;
               state_in = S_ILOOP;
            end
         end
         S_CHK: begin
            if (mm_done) begin
               if (mm_p == MOD_WIDTH'(1)) begin
                  res_in  = pw_ff;
                  flag_in = 1'b0;
               end else begin
                  res_in  = '0;
                  flag_in = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               rsp_flag_in   = flag_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state, modulus, working registers and output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mod_ff       <= MOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mod_ff <= csr_modulus;
         end
      end
      op_ff         <= op_in;
      opb_ff        <= opb_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      sel_b_ff      <= sel_b_in;
      cnt_ff        <= cnt_in;
      r_ff          <= r_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      sq_ff         <= sq_in;
      pw_ff         <= pw_in;
      e_ff          <= e_in;
      res_ff        <= res_in;
      flag_ff       <= flag_in;
      rsp_result_ff <= rsp_result_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_result_ff;
   assign rsp_no_inverse = rsp_flag_ff;
endmodule

// ===== sim/tb_prime_field_alu.sv =====
// Self-checking testbench for the prime field arithmetic unit.
`timescale 1ns / 1ps

module tb_prime_field_alu;
   import pfa_pkg::*;

   typedef struct packed {
      op_type      op;
      logic [15:0] a;
      logic [15:0] b;
   } field_req_type;

   typedef struct packed {
      residue_type value;
      logic        no_inv;
   } field_rsp_type;

   // directed row: request, plus a typed-in answer where it is obvious
   typedef struct packed {
      field_req_type rq;
      logic          fixed;
      field_rsp_type answer;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   op_type req_type = OP_ADD;
   logic signed [15:0] req_operand_a = '0;
   logic signed [15:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   residue_type rsp_result;
   logic rsp_no_inverse;
   logic csr_valid = 1'b0;
   logic csr_ready;
   residue_type csr_modulus = '0;

   residue_type   field_mod;
   field_rsp_type pending_rsp[$];
   int            fail_count = 0;
   bit            stim_done = 1'b0;
   bit            hold_off = 1'b0;

   prime_field_alu #(.OPERAND_WIDTH(16)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .rsp_no_inverse(rsp_no_inverse),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_modulus(csr_modulus)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned residue_of(longint v, longint unsigned m);
      longint r;
      begin
         r = v % longint'(m);
         if (r < 0) r += longint'(m);
         return longint'(r);
      end
   endfunction

   // work out the answer for one request under the current modulus
   function automatic field_rsp_type field_answer(field_req_type rq);
      longint unsigned m, x, acc, sq, e;
      longint sa, sb;
      field_rsp_type r;
      begin
         m = 64'(field_mod);
         sa = longint'($signed(rq.a));
         sb = longint'($signed(rq.b));
         r = '0;
         if (m < 2) begin
            r.no_inv = (rq.op == OP_INV);
         end else begin
            case (rq.op)
               OP_ADD: r.value = residue_type'(residue_of(sa + sb, m));
               OP_MUL: r.value = residue_type'(residue_of(sa * sb, m));
               OP_RED: r.value = residue_type'(residue_of(sa, m));
               default: begin
                  x = residue_of(sa, m);
                  if (x == 1) r.value = residue_type'(1);
                  else if (x == m - 1) r.value = residue_type'(m - 1);
                  else begin
                     e = m - 2;
                     sq = x;
                     acc = e[0] ? x : 64'd1;
                     e >>= 1;
                     while (e != 0) begin
                        sq = (sq * sq) % m;
                        if (e[0]) acc = (acc * sq) % m;
                        e >>= 1;
                     end
                     if ((acc * x) % m != 1) r.no_inv = 1'b1;
                     else r.value = residue_type'(acc);
                  end
               end
            endcase
         end
         return r;
      end
   endfunction

   // write the modulus while idle
   task automatic write_modulus(residue_type m);
      begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_modulus <= m;
         do @(posedge clock); while (!csr_ready);
         field_mod = m;
         @(negedge clock);
         csr_valid <= 1'b0;
      end
   endtask

   // drop the request, wait until every answer is back, then let the block settle
   task automatic drain;
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (40) @(posedge clock);
      end
   endtask

   // send one request beat, with a random gap first
   task automatic send_req(field_req_type rq, bit fixed, field_rsp_type answer);
      int gap;
      begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
               ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
         @(negedge clock);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_type <= rq.op;
         req_operand_a <= rq.a;
         req_operand_b <= rq.b;
         do @(posedge clock); while (req_stall);
         if (fixed) pending_rsp.push_back(answer);
         else pending_rsp.push_back(field_answer(rq));
      end
   endtask

   function automatic logic [15:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 16'h8000 | 16'($urandom_range(0, 3));
         1: return 16'h7fff - 16'($urandom_range(0, 3));
         2: return 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   // stall the result side at random, with one long forced hold-off
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 2) == 0) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= ~rsp_stall;
   end

   initial begin
      #20000;
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   // compare each result beat with the oldest pending answer
   always @(posedge clock) begin
      field_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result beat: result %0d no_inverse %0d",
                   rsp_result, rsp_no_inverse);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_result !== exp_rsp.value) begin
               $error("result: expected %0d, got %0d", exp_rsp.value, rsp_result);
               fail_count++;
            end
            if (rsp_no_inverse !== exp_rsp.no_inv) begin
               $error("no_inverse: expected %0d, got %0d",
                      exp_rsp.no_inv, rsp_no_inverse);
               fail_count++;
            end
         end
      end
   end

   directed_row_type directed_rows[] = '{
      '{'{OP_ADD, 16'h7fff, 16'h7fff}, 1'b0, '0},
      '{'{OP_ADD, 16'h8000, 16'h8000}, 1'b0, '0},
      '{'{OP_MUL, 16'h8000, 16'h8000}, 1'b0, '0},
      '{'{OP_MUL, 16'h7fff, 16'h8000}, 1'b0, '0},
      '{'{OP_MUL, 16'hffff, 16'hffff}, 1'b1, '{15'd1, 1'b0}},
      '{'{OP_RED, 16'h0000, 16'h1234}, 1'b1, '{15'd0, 1'b0}},
      '{'{OP_RED, 16'hffff, 16'h0000}, 1'b1, '{15'd32748, 1'b0}},
      '{'{OP_RED, 16'h7fff, 16'hffff}, 1'b1, '{15'd18, 1'b0}},
      '{'{OP_RED, 16'h8000, 16'h0000}, 1'b0, '0},
      '{'{OP_INV, 16'h0001, 16'h0000}, 1'b1, '{15'd1, 1'b0}},
      '{'{OP_INV, 16'hffff, 16'h0000}, 1'b1, '{15'd32748, 1'b0}},
      '{'{OP_INV, 16'h0000, 16'h0000}, 1'b1, '{15'd0, 1'b1}},
      '{'{OP_INV, 16'h7fed, 16'h0000}, 1'b1, '{15'd0, 1'b1}},
      '{'{OP_INV, 16'h0002, 16'h0000}, 1'b0, '0},
      '{'{OP_INV, 16'h8000, 16'h0000}, 1'b0, '0}
   };

   residue_type mod_choices[] = '{15'd32749, 15'd2, 15'd3, 15'd13, 15'd15,
                                  15'd0, 15'd1, 15'd32767, 15'd251, 15'd32749};

   // stimulus: reset, directed table, then random phases over several moduli
   initial begin
      field_req_type rq;
      field_mod = MOD_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_req(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].answer);
      drain();
      foreach (mod_choices[p]) begin
         write_modulus(mod_choices[p]);
         repeat (55) begin
            rq.op = op_type'($urandom_range(0, 3));
            rq.a = rand_operand();
            rq.b = rand_operand();
            send_req(rq, 1'b0, '0);
         end
         drain();
      end
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
